>>> design/pfr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pfr_pkg
// Shared types, constants and arithmetic helpers of the polyphase resampler.
// ----------------------------------------------------------------------------
package pfr_pkg;

	// Default sizes of the filter.
	localparam int TAPS_DEF   = 16;
	localparam int PHASES_DEF = 16;

	// Fixed formats.
	localparam int SMP_W     = 16;
	localparam int PH_W      = 28;
	localparam int ACC_W     = 40;
	localparam int BURST_CAP = 16;
	localparam int CNT_W     = 5;
	localparam int HALF_Q16  = 32768;
	localparam int ONE_Q16   = 65536;

	// Configuration port.
	localparam int PADDR_W = 4;
	localparam logic [1:0] REG_INTERP = 2'd0;
	localparam logic [1:0] REG_STEP   = 2'd1;
	localparam logic [1:0] REG_BYPASS = 2'd2;

	// Flags that travel with each tap read into the multiply-accumulate unit.
	typedef struct packed {
		logic issue;
		logic first;
		logic last;
	} pfr_mac_ctl_t;

	// Saturate a 29-bit phase value to the 28-bit signed range.
	function automatic logic signed [PH_W-1:0] sat_phase(input logic signed [PH_W:0] v);
		logic signed [PH_W-1:0] r;
		if (v[PH_W] != v[PH_W-1]) begin
			r = v[PH_W] ? {1'b1, {(PH_W-1){1'b0}}} : {1'b0, {(PH_W-1){1'b1}}};
		end else begin
			r = v[PH_W-1:0];
		end
		return r;
	endfunction

	// Round a Q2.30 product sum to nearest (ties upward) and saturate to 16 bits.
	function automatic logic signed [SMP_W-1:0] round_sat(input logic signed [ACC_W-1:0] acc);
		logic signed [ACC_W-1:0] x;
		logic signed [ACC_W-1:0] r;
		logic signed [SMP_W-1:0] y;
		x = acc + ACC_W'(16384);
		r = x >>> 15;
		if (r > ACC_W'(32767)) begin
			y = 16'sh7fff;
		end else if (r < -ACC_W'(32768)) begin
			y = 16'sh8000;
		end else begin
			y = r[SMP_W-1:0];
		end
		return y;
	endfunction

endpackage
`default_nettype wire

>>> design/pfr_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pfr_in_if / pfr_out_if
// Valid-ready channels for input items and for result items.
// ----------------------------------------------------------------------------
interface pfr_in_if;
	logic        valid;
	logic        ready;
	logic        cmd;
	logic [15:0] sample_i;
	logic [15:0] sample_q;
	logic [3:0]  tap_phase;
	logic [3:0]  tap_position;
	logic [15:0] tap_value;

	modport source (output valid, cmd, sample_i, sample_q, tap_phase, tap_position,
		tap_value, input ready);
	modport sink (input valid, cmd, sample_i, sample_q, tap_phase, tap_position,
		tap_value, output ready);
endinterface

interface pfr_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] out_i;
	logic [15:0] out_q;
	logic        last;

	modport source (output valid, out_i, out_q, last, input ready);
	modport sink (input valid, out_i, out_q, last, output ready);
endinterface
`default_nettype wire

>>> design/pfr_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pfr_cell
// One entry of the complex sample line; takes its neighbour's value when enabled.
// ----------------------------------------------------------------------------
module pfr_cell (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        en,
	input  wire logic [15:0] d_i,
	input  wire logic [15:0] d_q,
	output logic      [15:0] q_i,
	output logic      [15:0] q_q
);
	// The line starts out as all zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_i <= '0;
			q_q <= '0;
		end else if (en) begin
			q_i <= d_i;
			q_q <= d_q;
		end
	end
endmodule
`default_nettype wire

>>> design/pfr_mac.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pfr_mac
// Tap memory and a complex multiply-accumulate fed one tap per cycle.
// ----------------------------------------------------------------------------
module pfr_mac #(
	parameter int TAPS_PER_PHASE = pfr_pkg::TAPS_DEF,
	parameter int MAX_PHASES     = pfr_pkg::PHASES_DEF,
	localparam int MAW           = $clog2(MAX_PHASES * TAPS_PER_PHASE)
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire pfr_pkg::pfr_mac_ctl_t         ctl,
	input  wire logic [MAW-1:0]                raddr,
	input  wire logic [15:0]                   line_i,
	input  wire logic [15:0]                   line_q,
	input  wire logic                          we,
	input  wire logic [MAW-1:0]                waddr,
	input  wire logic [15:0]                   wdata,
	output logic signed [pfr_pkg::ACC_W-1:0]   acc_i,
	output logic signed [pfr_pkg::ACC_W-1:0]   acc_q,
	output logic                               done
);
	import pfr_pkg::*;

	logic [15:0] tap_mem [MAX_PHASES * TAPS_PER_PHASE];

	logic signed [15:0] tap_s1, li_s1, lq_s1;
	logic signed [31:0] pi_s2, pq_s2;
	pfr_mac_ctl_t       ctl_s1, ctl_s2;

	// Tap memory: one write port for loads, one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			tap_mem[waddr] <= wdata;
		end
		tap_s1 <= tap_mem[raddr];
		li_s1  <= line_i;
		lq_s1  <= line_q;
	end

	// Products of the tap with both parts of the line entry.
	always_ff @(posedge clk) begin
		pi_s2 <= tap_s1 * li_s1;
		pq_s2 <= tap_s1 * lq_s1;
	end

	// Control flags follow the data down the pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			done   <= 1'b0;
		end else begin
			ctl_s1 <= ctl;
			ctl_s2 <= ctl_s1;
			done   <= ctl_s2.issue && ctl_s2.last;
		end
	end

	// The accumulator restarts on the first tap of each output.
	always_ff @(posedge clk) begin
		if (ctl_s2.issue) begin
			if (ctl_s2.first) begin
				acc_i <= ACC_W'(pi_s2);
				acc_q <= ACC_W'(pq_s2);
			end else begin
				acc_i <= acc_i + ACC_W'(pi_s2);
				acc_q <= acc_q + ACC_W'(pq_s2);
			end
		end
	end
endmodule
`default_nettype wire

>>> design/polyphase_fractional_resampler.sv
`default_nettype none
// ----------------------------------------------------------------------------
// polyphase_fractional_resampler
// Polyphase FIR resampler for complex samples with a rounded phase accumulator.
// ----------------------------------------------------------------------------
//  channel    direction  handshake      carries
//  samples    in         valid/ready    cmd, sample_i/q, tap_phase/position/value
//  results    out        valid/ready    out_i, out_q, last
//  APB        in         psel/penable   interp_factor, decimate_step, bypass
//
//  A tap load or a sample that does not fill the line leaves the block in S_IDLE.
//  Each output is a product sum over one full rotation of the sample line
//  through one complex MAC, then the MAC pipeline drains and hands it off.
//  A sample gives a burst of at most 16 outputs.
//  Reset clears line, fill, phase, bypass; interp=1, step=65536; taps stay unknown.
//  A stalled result holds the burst until the output register is taken.
// ----------------------------------------------------------------------------
module polyphase_fractional_resampler #(
	parameter int TAPS_PER_PHASE = pfr_pkg::TAPS_DEF,
	parameter int MAX_PHASES     = pfr_pkg::PHASES_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	pfr_in_if.sink                            samples,
	pfr_out_if.source                         results,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [pfr_pkg::PADDR_W-1:0]  paddr,
	input  wire logic [31:0]                  pwdata,
	output logic      [31:0]                  prdata,
	output logic                              pready
);
	import pfr_pkg::*;

	localparam int MAW = $clog2(MAX_PHASES * TAPS_PER_PHASE);
	localparam int KW  = $clog2(TAPS_PER_PHASE);
	localparam int FW  = $clog2(TAPS_PER_PHASE + 1);
	localparam int PAW = (MAX_PHASES > 1) ? $clog2(MAX_PHASES) : 1;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_CHECK = 3'd1;
	localparam logic [2:0] S_MAC   = 3'd2;
	localparam logic [2:0] S_DRAIN = 3'd3;
	localparam logic [2:0] S_EMIT  = 3'd4;

	logic [2:0]  state_q;
	logic [4:0]  interp_q;
	logic [23:0] step_q;
	logic        bypass_q;

	logic signed [PH_W-1:0] phase_q;
	logic [FW-1:0]          fill_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [KW-1:0]          k_q;
	logic [PAW-1:0]         addr_q;
	logic                   cont_q;
	logic                   byp_emit_q;
	logic [15:0]            res_i_q, res_q_q;

	logic        ov_q;
	logic [15:0] oi_q, oq_q;
	logic        olast_q;

	// ------------------------------------------------------------------
	// Configuration registers.
	// ------------------------------------------------------------------
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interp_q <= 5'd1;
			step_q   <= 24'd65536;
			bypass_q <= 1'b0;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[3:2])
				REG_INTERP: interp_q <= pwdata[4:0];
				REG_STEP:   step_q   <= pwdata[23:0];
				REG_BYPASS: bypass_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_INTERP: prdata = {27'd0, interp_q};
			REG_STEP:   prdata = {8'd0, step_q};
			REG_BYPASS: prdata = {31'd0, bypass_q};
			default:    prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// Handshakes and decode of the incoming item.
	// ------------------------------------------------------------------
	logic acc_in, is_tap, slot_free, tap_ok;
	assign samples.ready = (state_q == S_IDLE);
	assign acc_in    = samples.valid && samples.ready;
	assign is_tap    = samples.cmd;
	assign slot_free = !ov_q || results.ready;
	assign tap_ok    = (int'(samples.tap_phase) < MAX_PHASES) &&
	                   (int'(samples.tap_position) < TAPS_PER_PHASE);

	// ------------------------------------------------------------------
	// Phase address and burst decision.
	// ------------------------------------------------------------------
	logic signed [PH_W:0]   t_c, sub_c, add_c;
	logic [PH_W-17:0]       t_hi;
	logic                   stop_c, cont_c;
	logic [PAW-1:0]         addr_c;

	assign t_c    = {phase_q[PH_W-1], phase_q} + (PH_W+1)'(HALF_Q16);
	assign stop_c = t_c <= -(PH_W+1)'(ONE_Q16);
	assign t_hi   = t_c[PH_W-1:16];
	assign cont_c = (cnt_q < CNT_W'(BURST_CAP)) && !stop_c;
	assign sub_c  = {phase_q[PH_W-1], phase_q} - $signed({5'd0, step_q});
	assign add_c  = {phase_q[PH_W-1], phase_q} + $signed({8'd0, interp_q, 16'd0});

	always_comb begin
		if (t_c[PH_W]) begin
			addr_c = '0;
		end else if (int'(t_hi) > MAX_PHASES - 1) begin
			addr_c = PAW'(MAX_PHASES - 1);
		end else begin
			addr_c = t_hi[PAW-1:0];
		end
	end

	// ------------------------------------------------------------------
	// Sample line: a row of cells that shifts on a new sample and rotates
	// once round during each output's product sum.
	// ------------------------------------------------------------------
	logic [15:0] ln_i [TAPS_PER_PHASE];
	logic [15:0] ln_q [TAPS_PER_PHASE];
	logic        shift_new, rotate, line_en;
	logic [15:0] tail_i, tail_q;

	assign shift_new = acc_in && !is_tap && !bypass_q;
	assign rotate    = (state_q == S_MAC);
	assign line_en   = shift_new || rotate;
	assign tail_i    = rotate ? ln_i[0] : samples.sample_i;
	assign tail_q    = rotate ? ln_q[0] : samples.sample_q;

	for (genvar g = 0; g < TAPS_PER_PHASE; g++) begin : g_line
		if (g == TAPS_PER_PHASE - 1) begin : g_tail
			pfr_cell u_cell (
				.clk(clk), .arst_n(arst_n), .en(line_en),
				.d_i(tail_i), .d_q(tail_q), .q_i(ln_i[g]), .q_q(ln_q[g])
			);
		end else begin : g_body
			pfr_cell u_cell (
				.clk(clk), .arst_n(arst_n), .en(line_en),
				.d_i(ln_i[g+1]), .d_q(ln_q[g+1]), .q_i(ln_i[g]), .q_q(ln_q[g])
			);
		end
	end

	// ------------------------------------------------------------------
	// Multiply-accumulate unit with the tap memory.
	// ------------------------------------------------------------------
	pfr_mac_ctl_t               mac_ctl;
	logic [MAW-1:0]             raddr, waddr;
	logic                       tap_we, mac_done;
	logic signed [ACC_W-1:0]    acc_i, acc_q;

	assign mac_ctl.issue = rotate;
	assign mac_ctl.first = (k_q == '0);
	assign mac_ctl.last  = (int'(k_q) == TAPS_PER_PHASE - 1);
	assign raddr  = MAW'(int'(addr_q) * TAPS_PER_PHASE + int'(k_q));
	assign waddr  = MAW'(int'(samples.tap_phase) * TAPS_PER_PHASE + int'(samples.tap_position));
	assign tap_we = acc_in && is_tap && tap_ok;

	pfr_mac #(
		.TAPS_PER_PHASE(TAPS_PER_PHASE),
		.MAX_PHASES(MAX_PHASES)
	) u_mac (
		.clk(clk), .arst_n(arst_n), .ctl(mac_ctl), .raddr(raddr),
		.line_i(ln_i[0]), .line_q(ln_q[0]),
		.we(tap_we), .waddr(waddr), .wdata(samples.tap_value),
		.acc_i(acc_i), .acc_q(acc_q), .done(mac_done)
	);

	// ------------------------------------------------------------------
	// Sequencer: per sample, the burst of outputs and the phase updates.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			phase_q    <= '0;
			fill_q     <= '0;
			cnt_q      <= '0;
			k_q        <= '0;
			addr_q     <= '0;
			cont_q     <= 1'b0;
			byp_emit_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (acc_in && !is_tap) begin
						if (bypass_q) begin
							cont_q     <= 1'b0;
							byp_emit_q <= 1'b1;
							state_q    <= S_EMIT;
						end else begin
							cnt_q <= '0;
							if (int'(fill_q) < TAPS_PER_PHASE) begin
								fill_q <= fill_q + FW'(1);
							end
							if (int'(fill_q) >= TAPS_PER_PHASE - 1) begin
								state_q <= S_CHECK;
							end
						end
					end
				end
				S_CHECK: begin
					addr_q     <= addr_c;
					k_q        <= '0;
					byp_emit_q <= 1'b0;
					if (cnt_q == '0) begin
						if (stop_c) begin
							phase_q <= sat_phase(add_c);
							state_q <= S_IDLE;
						end else begin
							state_q <= S_MAC;
						end
					end else begin
						cont_q  <= cont_c;
						state_q <= S_EMIT;
					end
				end
				S_MAC: begin
					k_q <= k_q + KW'(1);
					if (int'(k_q) == TAPS_PER_PHASE - 1) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (mac_done) begin
						phase_q <= sat_phase(sub_c);
						cnt_q   <= cnt_q + CNT_W'(1);
						state_q <= S_CHECK;
					end
				end
				S_EMIT: begin
					if (slot_free) begin
						k_q <= '0;
						if (cont_q) begin
							state_q <= S_MAC;
						end else begin
							if (!byp_emit_q) begin
								phase_q <= sat_phase(add_c);
							end
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Result, or a bypassed sample, held between the product sum and the output register.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && acc_in) begin
			res_i_q <= samples.sample_i;
			res_q_q <= samples.sample_q;
		end else if (state_q == S_DRAIN && mac_done) begin
			res_i_q <= round_sat(acc_i);
			res_q_q <= round_sat(acc_q);
		end
	end

	// ------------------------------------------------------------------
	// Output register.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (state_q == S_EMIT && slot_free) begin
			ov_q <= 1'b1;
		end else if (results.ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_EMIT && slot_free) begin
			oi_q    <= res_i_q;
			oq_q    <= res_q_q;
			olast_q <= !cont_q;
		end
	end

	assign results.valid = ov_q;
	assign results.out_i = oi_q;
	assign results.out_q = oq_q;
	assign results.last  = olast_q;
endmodule
`default_nettype wire

>>> test/polyphase_fractional_resampler_tb.sv
// ----------------------------------------------------------------------------
// polyphase_fractional_resampler_tb
// The testbench loads the tap memory and then drives samples through
// several rate settings, bypass, burst-cap and saturation cases and a
// random mix. Every result is compared with a local prediction of the
// filter.
// ----------------------------------------------------------------------------
module polyphase_fractional_resampler_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import pfr_pkg::*;

	typedef struct {
		logic signed [15:0] re;
		logic signed [15:0] im;
		logic               last;
	} resampled_t;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	pfr_in_if  smp_if ();
	pfr_out_if res_if ();

	polyphase_fractional_resampler i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (smp_if),
		.results (res_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Local copy of the filter state and its settings.
	logic signed [15:0] coef_mem [0:255];
	logic signed [15:0] hist_i [0:15];
	logic signed [15:0] hist_q [0:15];
	int unsigned        hist_fill;
	longint             phase_acc;
	int unsigned        cur_interp;
	longint             cur_step;
	logic               cur_bypass;

	resampled_t expected_out[$];

	int unsigned mismatches;
	int unsigned sample_count, load_count, output_count, burst_caps;
	bit          tx_gaps_on;
	int unsigned rx_mode;

	// Clock.
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Limit on the whole run.
	initial begin
		#20ms;
		$display("** polyphase_fractional_resampler: FAILED **");
		$finish;
	end

	function automatic longint clamp_phase(input longint p);
		if (p > 134217727) return 134217727;
		if (p < -134217728) return -134217728;
		return p;
	endfunction

	// Round to nearest with ties upward, then saturate to 16 bits.
	function automatic logic signed [15:0] round_out(input longint acc);
		longint r;
		r = (acc + 16384) >>> 15;
		if (r > 32767) r = 32767;
		if (r < -32768) r = -32768;
		return r[15:0];
	endfunction

	// Work out the results of one accepted sample and queue them.
	function automatic void predict_sample(input logic signed [15:0] si,
		input logic signed [15:0] sq);
		resampled_t r;
		longint t, addr, acc_i, acc_q;
		int n;
		n = 0;
		if (cur_bypass) begin
			r.re = si;
			r.im = sq;
			r.last = 1'b1;
			expected_out.push_back(r);
			return;
		end
		for (int k = 0; k < 15; k++) begin
			hist_i[k] = hist_i[k+1];
			hist_q[k] = hist_q[k+1];
		end
		hist_i[15] = si;
		hist_q[15] = sq;
		if (hist_fill < 16) hist_fill++;
		if (hist_fill < 16) return;
		while (n < BURST_CAP) begin
			t = phase_acc + HALF_Q16;
			if (t <= -ONE_Q16) break;
			addr = (t >= 0) ? (t >>> 16) : 0;
			if (addr > 15) addr = 15;
			acc_i = 0;
			acc_q = 0;
			for (int k = 0; k < 16; k++) begin
				acc_i += longint'(coef_mem[addr*16+k]) * longint'(hist_i[k]);
				acc_q += longint'(coef_mem[addr*16+k]) * longint'(hist_q[k]);
			end
			r.re = round_out(acc_i);
			r.im = round_out(acc_q);
			r.last = 1'b0;
			expected_out.push_back(r);
			n++;
			phase_acc = clamp_phase(phase_acc - cur_step);
		end
		if (n == BURST_CAP) burst_caps++;
		if (n > 0) expected_out[$].last = 1'b1;
		phase_acc = clamp_phase(phase_acc + longint'(cur_interp) * ONE_Q16);
	endfunction

	// Gap length: mostly none, sometimes short, now and then long.
	function automatic int unsigned pick_gap();
		int unsigned p;
		p = $urandom_range(99);
		if (p < 60) return 0;
		if (p < 93) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// Sample value with a bias towards the extremes.
	function automatic logic [15:0] pick_value();
		case ($urandom_range(9))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h0000;
			3: return 16'hffff;
			default: return 16'($urandom());
		endcase
	endfunction

	// Send one item and update the prediction once it is taken.
	task automatic send_item(input logic cmd, input logic [15:0] si, input logic [15:0] sq,
		input logic [3:0] tph, input logic [3:0] tpos, input logic [15:0] tval);
		int unsigned gap;
		gap = tx_gaps_on ? pick_gap() : 0;
		if (gap > 0) begin
			smp_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		smp_if.valid        <= 1'b1;
		smp_if.cmd          <= cmd;
		smp_if.sample_i     <= si;
		smp_if.sample_q     <= sq;
		smp_if.tap_phase    <= tph;
		smp_if.tap_position <= tpos;
		smp_if.tap_value    <= tval;
		@(posedge clk);
		while (!smp_if.ready) @(posedge clk);
		if (cmd) begin
			coef_mem[{tph, tpos}] = tval;
			load_count++;
		end else begin
			predict_sample(si, sq);
			sample_count++;
		end
	endtask

	task automatic send_sample(input logic [15:0] si, input logic [15:0] sq);
		send_item(1'b0, si, sq, 4'($urandom()), 4'($urandom()), 16'($urandom()));
	endtask

	task automatic send_tap(input logic [3:0] tph, input logic [3:0] tpos,
		input logic [15:0] tval);
		send_item(1'b1, 16'($urandom()), 16'($urandom()), tph, tpos, tval);
	endtask

	// Lower valid and wait until every expected result has arrived.
	task automatic drain();
		smp_if.valid <= 1'b0;
		@(posedge clk);
		while (expected_out.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_INTERP: cur_interp = value[4:0];
			REG_STEP:   cur_step   = value[23:0];
			REG_BYPASS: cur_bypass = value[0];
			default: ;
		endcase
	endtask

	task automatic set_rates(input int unsigned l, input int unsigned step, input bit byp);
		drain();
		reg_write(REG_INTERP, 32'(l));
		reg_write(REG_STEP, 32'(step));
		reg_write(REG_BYPASS, 32'(byp));
	endtask

	// Fill the whole tap memory, with every extreme among the values.
	task automatic test_tap_load();
		for (int p = 0; p < 16; p++) begin
			for (int k = 0; k < 16; k++) begin
				send_tap(4'(p), 4'(k),
					(p == 0) ? 16'h8000 : (p == 15) ? 16'h7fff : pick_value());
			end
		end
	endtask

	// Directed: saturation both ways, bypass, the lowest step with L at most, and the highest step with L of one.
	task automatic test_directed();
		set_rates(1, 65536, 1'b0);
		for (int n = 0; n < 16; n++) send_sample(16'h8000, 16'h7fff);
		send_sample(16'h7fff, 16'h8000);
		send_sample(16'h0000, 16'hffff);
		set_rates(1, 65536, 1'b1);
		send_sample(16'h8000, 16'h7fff);
		send_sample(16'h1234, 16'hedcb);
		set_rates(16, 4096, 1'b0);
		for (int n = 0; n < 4; n++) send_sample(pick_value(), pick_value());
		set_rates(1, 16711680, 1'b0);
		for (int n = 0; n < 4; n++) send_sample(pick_value(), pick_value());
	endtask

	// Random mix of samples and tap reloads across several rate settings.
	task automatic test_random(input int unsigned items);
		int unsigned sel;
		for (int n = 0; n < items; n++) begin
			if (n % 6 == 0) begin
				sel = $urandom_range(5);
				case (sel)
					0: set_rates(1, 65536, 1'b0);
					1: set_rates(16, 16711680, 1'b0);
					2: set_rates($urandom_range(1, 16), $urandom_range(4096, 262144), 1'b0);
					3: set_rates($urandom_range(2, 5), $urandom_range(8192, 65536), 1'b0);
					4: set_rates(1, 65536, 1'b1);
					default: set_rates($urandom_range(1, 16),
						$urandom_range(4096, 16711680), 1'b0);
				endcase
				tx_gaps_on = ($urandom_range(3) != 0);
				rx_mode = $urandom_range(2);
			end
			if (n == items / 2) drain();
			if ($urandom_range(9) == 0) begin
				send_tap(4'($urandom()), 4'($urandom()), pick_value());
			end else begin
				send_sample(pick_value(), pick_value());
			end
		end
	endtask

	// Result acceptor: ready with random stalls, or always ready in mode zero.
	int unsigned stall_left;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stall_left <= 0;
			res_if.ready <= 1'b0;
		end else if (rx_mode == 0) begin
			res_if.ready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			res_if.ready <= 1'b0;
		end else begin
			stall_left <= pick_gap();
			res_if.ready <= 1'b1;
		end
	end

	// Compare each accepted result with the oldest expectation.
	always @(posedge clk) begin
		resampled_t e;
		if (arst_n && res_if.valid && res_if.ready) begin
			output_count++;
			if (expected_out.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected item: i=%0d q=%0d last=%0b",
						$signed(res_if.out_i), $signed(res_if.out_q), res_if.last);
			end else begin
				e = expected_out.pop_front();
				if (res_if.out_i !== e.re || res_if.out_q !== e.im
					|| res_if.last !== e.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected i=%0d q=%0d last=%0b, got i=%0d q=%0d last=%0b",
							e.re, e.im, e.last, $signed(res_if.out_i),
							$signed(res_if.out_q), res_if.last);
				end
			end
		end
	end

	initial begin
		for (int k = 0; k < 256; k++) coef_mem[k] = '0;
		for (int k = 0; k < 16; k++) begin
			hist_i[k] = '0;
			hist_q[k] = '0;
		end
		hist_fill = 0;
		phase_acc = 0;
		cur_interp = 1;
		cur_step = 65536;
		cur_bypass = 1'b0;
		mismatches = 0;
		sample_count = 0;
		load_count = 0;
		output_count = 0;
		burst_caps = 0;
		tx_gaps_on = 1'b1;
		rx_mode = 1;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		smp_if.valid <= 1'b0;
		smp_if.cmd <= 1'b0;
		smp_if.sample_i <= '0;
		smp_if.sample_q <= '0;
		smp_if.tap_phase <= '0;
		smp_if.tap_position <= '0;
		smp_if.tap_value <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_tap_load();
		test_directed();
		test_random(26);

		drain();
		$display("Run covered %0d samples and %0d tap loads, %0d outputs checked.",
			sample_count, load_count, output_count);
		$display("Bursts that reached the cap: %0d; mismatches: %0d.", burst_caps, mismatches);
		if (mismatches == 0) begin
			$display("** polyphase_fractional_resampler: PASSED **");
		end else begin
			$display("** polyphase_fractional_resampler: FAILED **");
		end
		$finish;
	end

endmodule

>>> files.f
design/pfr_pkg.sv
design/pfr_if.sv
design/pfr_cell.sv
design/pfr_mac.sv
design/polyphase_fractional_resampler.sv
test/polyphase_fractional_resampler_tb.sv
